>>> rtl/cib_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cib_pkg: shared types and constants of the codeword interleave buffer
// Ring geometry, item and status codes, and the slot memory entry format.
// ---------------------------------------------------------------------------
package cib_pkg;

	localparam int BUFFER_DEPTH      = 32;
	localparam int NUM_CODERS        = 16;
	localparam int MAX_CODEWORD_BITS = 32;
	localparam int MAX_RESULTS       = 32;

	localparam int PTR_W   = $clog2(BUFFER_DEPTH);
	localparam int FREE_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int CODER_W = $clog2(NUM_CODERS);
	localparam int CNT_W   = $clog2(MAX_RESULTS);
	localparam int VAL_W   = 32;
	localparam int LEN_W   = 6;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_WRITE   = 2'd1,
		OP_FINISH  = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_DUP      = 3'd2,
		STAT_NO_RES   = 3'd3,
		STAT_ZERO_LEN = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_DRAIN = 1'b1
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [VAL_W-1:0] value;
	} slot_entry_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		slot_entry_t      data;
	} slot_wr_t;

endpackage

>>> rtl/cib_slot_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cib_slot_mem: codeword slot storage
// One write port and one registered read port over the ring slots.
// ---------------------------------------------------------------------------
module cib_slot_mem (
	input  logic                        clk,
	input  cib_pkg::slot_wr_t           wr,
	input  logic                        rd_en,
	input  logic [cib_pkg::PTR_W-1:0]   rd_addr,
	output cib_pkg::slot_entry_t        rd_data
);
	import cib_pkg::*;

	slot_entry_t mem [BUFFER_DEPTH];
	slot_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// hold the last read while the consumer stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/codeword_interleave_buffer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// codeword_interleave_buffer_core: entropy-coder codeword interleaver
// Coders reserve ring slots in order, fill them later, and completed slots
// leave in ring order as codewords.
// ---------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | op, coder_id, codeword_value, codeword_length
//  out     | out_valid/out_ready | has_codeword, out_value, out_length, last, status
//
// Reserve, finish, restart, rejected requests and writes that drain nothing
// each give one result. A write that completes the oldest slot gives N
// codewords, one per cycle from the slot memory while the output is not stalled.
// Reset clears ready bits, reservations and pointers; slots are read only when ready.
// A stall on the output holds the result register and the memory read data,
// and no new request is taken until the result register can be refilled.
// ---------------------------------------------------------------------------
module codeword_interleave_buffer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [3:0]                    coder_id,
	input  logic [31:0]                   codeword_value,
	input  logic [5:0]                    codeword_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          has_codeword,
	output logic [31:0]                   out_value,
	output logic [5:0]                    out_length,
	output logic                          last,
	output logic [2:0]                    status
);
	import cib_pkg::*;

	// ring bookkeeping
	logic [BUFFER_DEPTH-1:0] rdy_q;          // slot written and waiting to drain
	logic [PTR_W-1:0]        coder_slot_q [NUM_CODERS];
	logic [NUM_CODERS-1:0]   coder_has_q;
	logic [PTR_W-1:0]        dp_q;           // oldest pending slot
	logic [PTR_W-1:0]        rp_q;           // next slot to reserve
	logic [FREE_W-1:0]       free_q;
	logic [CNT_W-1:0]        cnt_q;          // codewords drained for this request
	state_t                  state_q, state_d;

	// result register
	logic        out_valid_q;
	logic        src_mem_q;                  // payload comes from the slot memory
	logic        fin_q;                      // terminator result
	logic        last_q;
	status_t     status_q;

	// request decode
	op_t                 op_in;
	logic [CODER_W-1:0]  cid;
	logic [PTR_W-1:0]    wslot;
	logic [LEN_W-1:0]    len_sat;
	logic [VAL_W:0]      mask_wide;
	logic                out_free;
	logic                take;
	logic                take_idle;
	logic                drain_issue;
	logic                write_ok;
	logic                reserve_ok;
	logic                will_drain;
	logic [PTR_W-1:0]    dp_next;
	logic                drain_last;
	status_t             status_new;

	slot_wr_t            mem_wr;
	slot_entry_t         mem_rd;

	assign op_in    = op_t'(op);
	assign cid      = coder_id[CODER_W-1:0];
	assign wslot    = coder_slot_q[cid];
	assign out_free = !out_valid_q || out_ready;

	// clamp the length and keep only the codeword bits below it
	assign len_sat   = (codeword_length > LEN_W'(MAX_CODEWORD_BITS)) ?
	                   LEN_W'(MAX_CODEWORD_BITS) : codeword_length;
	assign mask_wide = ((VAL_W+1)'(1) << len_sat) - (VAL_W+1)'(1);

	assign reserve_ok = (free_q != '0) && !coder_has_q[cid];
	assign write_ok   = coder_has_q[cid] && (codeword_length != '0);
	assign will_drain = rdy_q[dp_q] || (wslot == dp_q);

	assign dp_next    = dp_q + PTR_W'(1);
	assign drain_last = !rdy_q[dp_next] || (cnt_q == CNT_W'(MAX_RESULTS - 1));

	always_comb begin
		status_new = STAT_OK;
		case (op_in)
			OP_RESERVE: begin
				if (free_q == '0) status_new = STAT_FULL;
				else if (coder_has_q[cid]) status_new = STAT_DUP;
			end
			OP_WRITE: begin
				if (!coder_has_q[cid]) status_new = STAT_NO_RES;
				else if (codeword_length == '0) status_new = STAT_ZERO_LEN;
			end
			default: status_new = STAT_OK;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		take_idle   = 1'b0;
		drain_issue = 1'b0;
		case (state_q)
			S_IDLE:  take_idle   = out_free;
			S_DRAIN: drain_issue = out_free;
			default: begin
				take_idle   = 1'b0;
				drain_issue = 1'b0;
			end
		endcase
	end

	assign in_ready = take_idle;
	assign take     = in_valid && take_idle;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take && op_in == OP_WRITE && write_ok && will_drain) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (drain_issue && drain_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot write on an accepted codeword
	always_comb begin
		mem_wr            = '0;
		mem_wr.en         = take && op_in == OP_WRITE && write_ok;
		mem_wr.addr       = wslot;
		mem_wr.data.len   = len_sat;
		mem_wr.data.value = codeword_value & mask_wide[VAL_W-1:0];
	end

	cib_slot_mem u_slot_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (drain_issue),
		.rd_addr (dp_q),
		.rd_data (mem_rd)
	);

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q       <= '0;
			coder_has_q <= '0;
			dp_q        <= '0;
			rp_q        <= '0;
			free_q      <= FREE_W'(BUFFER_DEPTH);
			cnt_q       <= '0;
		end else begin
			if (take) begin
				cnt_q <= '0;
				case (op_in)
					OP_RESERVE: begin
						if (reserve_ok) begin
							coder_has_q[cid] <= 1'b1;
							rdy_q[rp_q]      <= 1'b0;
							rp_q             <= rp_q + PTR_W'(1);
							free_q           <= free_q - FREE_W'(1);
						end
					end
					OP_WRITE: begin
						if (write_ok) begin
							coder_has_q[cid] <= 1'b0;
							rdy_q[wslot]     <= 1'b1;
						end
					end
					OP_RESTART: begin
						rdy_q       <= '0;
						coder_has_q <= '0;
						dp_q        <= '0;
						rp_q        <= '0;
						free_q      <= FREE_W'(BUFFER_DEPTH);
					end
					default: ;
				endcase
			end else if (drain_issue) begin
				// retire the oldest slot and advance
				rdy_q[dp_q] <= 1'b0;
				dp_q        <= dp_next;
				cnt_q       <= cnt_q + CNT_W'(1);
				if (free_q < FREE_W'(BUFFER_DEPTH)) free_q <= free_q + FREE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && op_in == OP_RESERVE && reserve_ok) begin
			coder_slot_q[cid] <= rp_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			src_mem_q   <= 1'b0;
			fin_q       <= 1'b0;
			last_q      <= 1'b0;
			status_q    <= STAT_OK;
		end else if (out_free) begin
			if (drain_issue) begin
				out_valid_q <= 1'b1;
				src_mem_q   <= 1'b1;
				fin_q       <= 1'b0;
				last_q      <= drain_last;
				status_q    <= STAT_OK;
			end else if (take && !(op_in == OP_WRITE && write_ok && will_drain)) begin
				out_valid_q <= 1'b1;
				src_mem_q   <= 1'b0;
				fin_q       <= (op_in == OP_FINISH);
				last_q      <= 1'b1;
				status_q    <= status_new;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign has_codeword = src_mem_q || fin_q;
	assign out_value    = src_mem_q ? mem_rd.value : VAL_W'(fin_q);
	assign out_length   = src_mem_q ? mem_rd.len : LEN_W'(fin_q);
	assign last         = last_q;
	assign status       = status_q;

	// every reserved slot is either still held by a coder or written and waiting
	a_slot_accounting: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(rdy_q) + $countones(coder_has_q)) == (BUFFER_DEPTH - int'(free_q)))
		else $error("reserved slot count out of step with free count");

	// a drain read only targets a written slot
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		drain_issue |-> rdy_q[dp_q])
		else $error("drain read of a slot that is not ready");

	// no request is taken while codewords are draining
	a_no_take_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> !in_ready)
		else $error("request taken during drain");

	// restart empties the ring
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op_in == OP_RESTART) |=> (rdy_q == '0) && (coder_has_q == '0)
		&& (free_q == FREE_W'(BUFFER_DEPTH)))
		else $error("restart left ring state behind");

	// a write that starts a drain leaves the oldest slot ready to drain
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op_in == OP_WRITE && write_ok && will_drain) |=> rdy_q[dp_q])
		else $error("drain entered without a ready oldest slot");

endmodule
